// ===== hw/rtl/u8v_pkg.sv =====
// ----------------------------------------------------------------------------
// u8v_pkg
// Types, byte codes and helpers shared by the UTF-8 text validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

   localparam logic [7:0] BYTE_NUL     = 8'h00;
   localparam logic [7:0] BYTE_LF      = 8'h0A;
   localparam logic [7:0] BYTE_CR      = 8'h0D;
   localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
   localparam logic [7:0] LEAD2_LO     = 8'hC2;
   localparam logic [7:0] LEAD2_HI     = 8'hDF;
   localparam logic [7:0] LEAD3_LO     = 8'hE0;
   localparam logic [7:0] LEAD3_HI     = 8'hEF;
   localparam logic [7:0] LEAD4_LO     = 8'hF0;
   localparam logic [7:0] LEAD4_HI     = 8'hF4;
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_TAG     = 8'h80;

   localparam logic [7:0] MARK_BYTE0   = 8'hEF;
   localparam logic [7:0] MARK_BYTE1   = 8'hBB;
   localparam logic [7:0] MARK_BYTE2   = 8'hBF;

   localparam logic [20:0] MIN_THREE   = 21'h000800;
   localparam logic [20:0] MIN_FOUR    = 21'h010000;
   localparam logic [20:0] SURR_LO     = 21'h00D800;
   localparam logic [20:0] SURR_HI     = 21'h00DFFF;
   localparam logic [20:0] CODE_MAX    = 21'h10FFFF;

   localparam logic [2:0] SEQ_NONE     = 3'd0;
   localparam logic [2:0] SEQ_TWO      = 3'd2;
   localparam logic [2:0] SEQ_THREE    = 3'd3;
   localparam logic [2:0] SEQ_FOUR     = 3'd4;

   localparam logic [1:0] HEAD_DONE    = 2'd3;

   // ending_seen bit positions
   localparam int unsigned END_BIT_CRLF = 0;
   localparam int unsigned END_BIT_LF   = 1;
   localparam int unsigned END_BIT_BARE = 2;

   localparam logic [2:0] SEEN_CRLF    = 3'b001;
   localparam logic [2:0] SEEN_LF      = 3'b010;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_CRLF    = 2'd1;
   localparam logic [1:0] KIND_LF      = 2'd2;
   localparam logic [1:0] KIND_MIXED   = 2'd3;

   typedef struct packed {
      logic [1:0]  bytes_still_needed;
      logic [2:0]  seq_total_length;
      logic [20:0] value_accum;
      logic        failed;
      logic [1:0]  head_position;
      logic        mark_so_far;
      logic        cr_waiting;
      logic [2:0]  ending_seen;
   } u8v_state_type;

   typedef struct packed {
      logic       text_ok;
      logic       mark_found;
      logic [1:0] ending_kind;
   } u8v_result_type;

   localparam u8v_state_type STATE_RESET = '{
      bytes_still_needed: 2'd0,
      seq_total_length:   SEQ_NONE,
      value_accum:        21'd0,
      failed:             1'b0,
      head_position:      2'd0,
      mark_so_far:        1'b1,
      cr_waiting:         1'b0,
      ending_seen:        3'd0
   };

   function automatic logic [7:0] mark_byte(input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0:    b = MARK_BYTE0;
         2'd1:    b = MARK_BYTE1;
         default: b = MARK_BYTE2;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/u8v_step.sv =====
// ----------------------------------------------------------------------------
// u8v_step
// Single-pass update of the validator state for one request, plus the
// result computed when the request closes the buffer.
// ----------------------------------------------------------------------------
module u8v_step (
   input  u8v_pkg::u8v_state_type  state_cur,
   input  logic [7:0]              data_byte,
   input  logic                    byte_present,
   output u8v_pkg::u8v_state_type  state_nxt,
   output u8v_pkg::u8v_result_type result
);
   import u8v_pkg::*;

   u8v_state_type s;
   u8v_state_type closed;
   logic [20:0]   acc_shift;
   logic [1:0]    need_dec;
   logic          cont_ok;
   logic          bad_value;

   assign acc_shift = {state_cur.value_accum[14:0], data_byte[5:0]};
   assign need_dec  = state_cur.bytes_still_needed - 2'd1;
   assign cont_ok   = (data_byte & CONT_MASK) == CONT_TAG;
   assign bad_value = (state_cur.seq_total_length == SEQ_THREE && acc_shift < MIN_THREE) ||
                      (state_cur.seq_total_length == SEQ_FOUR && acc_shift < MIN_FOUR) ||
                      (acc_shift >= SURR_LO && acc_shift <= SURR_HI) ||
                      (acc_shift > CODE_MAX);

   always_comb begin
      s = state_cur;
      if (byte_present) begin
         // code point decoding
         if (data_byte == BYTE_NUL) begin
            s.failed = 1'b1;
         end
         if (state_cur.bytes_still_needed != 2'd0) begin
            if (!cont_ok) begin
               s.failed             = 1'b1;
               s.bytes_still_needed = 2'd0;
               s.seq_total_length   = SEQ_NONE;
               s.value_accum        = 21'd0;
            end else if (need_dec == 2'd0) begin
               if (bad_value) begin
                  s.failed = 1'b1;
               end
               s.bytes_still_needed = 2'd0;
               s.seq_total_length   = SEQ_NONE;
               s.value_accum        = 21'd0;
            end else begin
               s.bytes_still_needed = need_dec;
               s.value_accum        = acc_shift;
            end
         end else if (data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
            s.seq_total_length   = SEQ_TWO;
            s.bytes_still_needed = 2'd1;
            s.value_accum        = {16'd0, data_byte[4:0]};
         end else if (data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
            s.seq_total_length   = SEQ_THREE;
            s.bytes_still_needed = 2'd2;
            s.value_accum        = {17'd0, data_byte[3:0]};
         end else if (data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
            s.seq_total_length   = SEQ_FOUR;
            s.bytes_still_needed = 2'd3;
            s.value_accum        = {18'd0, data_byte[2:0]};
         end else if (data_byte > BYTE_ASCII_MAX) begin
            s.failed = 1'b1;
         end

         // leading mark
         if (state_cur.head_position != HEAD_DONE) begin
            if (data_byte != mark_byte(state_cur.head_position)) begin
               s.mark_so_far = 1'b0;
            end
            s.head_position = state_cur.head_position + 2'd1;
         end

         // line endings
         s.cr_waiting = 1'b0;
         if (state_cur.cr_waiting && data_byte == BYTE_LF) begin
            s.ending_seen[END_BIT_CRLF] = 1'b1;
         end else begin
            if (state_cur.cr_waiting) begin
               s.ending_seen[END_BIT_BARE] = 1'b1;
            end
            if (data_byte == BYTE_CR) begin
               s.cr_waiting = 1'b1;
            end else if (data_byte == BYTE_LF) begin
               s.ending_seen[END_BIT_LF] = 1'b1;
            end
         end
      end

      state_nxt = s;

      // close out the buffer on a copy; an open buffer keeps its pending state
      closed = s;
      if (closed.bytes_still_needed != 2'd0) begin
         closed.failed = 1'b1;
      end
      if (closed.cr_waiting) begin
         closed.ending_seen[END_BIT_BARE] = 1'b1;
      end

      result.text_ok    = !closed.failed;
      result.mark_found = closed.mark_so_far && (closed.head_position == HEAD_DONE);
      if (closed.failed || closed.ending_seen == 3'd0) begin
         result.ending_kind = KIND_NONE;
      end else if (closed.ending_seen == SEEN_CRLF) begin
         result.ending_kind = KIND_CRLF;
      end else if (closed.ending_seen == SEEN_LF) begin
         result.ending_kind = KIND_LF;
      end else begin
         result.ending_kind = KIND_MIXED;
      end
   end

endmodule

// ===== hw/rtl/utf8_text_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_text_validator
// Strict UTF-8 checker with byte order mark and line-ending detection.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle unless a last request waits behind a stalled
// response, and gives one response on each request marked last. Each request is
// held in the input register and each response in the result register; the whole
// per-byte state update runs in one pass between them. A request that closes a buffer
// waits in the input register only while a previous response is not taken.
module utf8_text_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_text_ok,
   output logic       rsp_mark_found,
   output logic [1:0] rsp_ending_kind
);
   import u8v_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_present_ff;
   logic           in_last_ff;
   u8v_state_type  state_ff;
   u8v_state_type  state_in;
   u8v_state_type  step_nxt;
   u8v_result_type step_res;
   logic           rsp_valid_ff;
   u8v_result_type rsp_ff;
   logic           advance;

   u8v_step u_step (
      .state_cur    (state_ff),
      .data_byte    (in_byte_ff),
      .byte_present (in_present_ff),
      .state_nxt    (step_nxt),
      .result       (step_res)
   );

   // a request with no response never waits on the output side
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign state_in  = in_last_ff ? STATE_RESET : step_nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff    <= req_data_byte;
         in_present_ff <= req_byte_present;
         in_last_ff    <= req_last;
      end
      if (advance && in_last_ff) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_ok     = rsp_ff.text_ok;
   assign rsp_mark_found  = rsp_ff.mark_found;
   assign rsp_ending_kind = rsp_ff.ending_kind;

endmodule

// ===== hw/rtl/u8v_checker.sv =====
// ----------------------------------------------------------------------------
// u8v_checker
// Port-level assertions for the UTF-8 text validator, bound to the top level.
// ----------------------------------------------------------------------------
module u8v_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_text_ok,
   input logic       rsp_mark_found,
   input logic [1:0] rsp_ending_kind
);
   import u8v_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_ok) &&
      $stable(rsp_mark_found) && $stable(rsp_ending_kind))
      else $error("stalled response changed");

   // invalid text reports no line-ending kind
   a_kind_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_text_ok |-> rsp_ending_kind == KIND_NONE)
      else $error("ending kind given for invalid text");

   // a fresh response follows an accepted last request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("response without a last request");

   // the input side stalls only behind a stalled response
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without output back-pressure");

endmodule

bind utf8_text_validator u8v_checker u_checker (.*);
